>>> hdl/sorted_flow_pause_scheduler_top_assert.svh
// assertion macros shared by the rtl, clocked on clk and held off during reset
`ifndef SORTED_FLOW_PAUSE_SCHEDULER_TOP_ASSERT_SVH
`define SORTED_FLOW_PAUSE_SCHEDULER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define SFPS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define SFPS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sfps_pkg.sv
package sfps_pkg;

	localparam int MAX_FLOWS_DEF = 16;

	localparam int CMD_W    = 2;
	localparam int ID_W     = 64;
	localparam int SIZE_W   = 32;
	localparam int THR_W    = 24;
	localparam int STATUS_W = 2;
	localparam int ACTION_W = 2;
	localparam int WIN_W    = 10;
	localparam int CFG_IDX_W = 1;

	localparam int IN_W  = 128;
	localparam int OUT_W = 16;

	localparam logic [THR_W-1:0] MIN_THR_RST = THR_W'(1280);
	localparam logic [THR_W-1:0] MAX_THR_RST = THR_W'(3840);
	localparam logic [WIN_W-1:0] PAUSE_WINDOW = WIN_W'(536);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SCHED  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_PAUSED  = 2'd1,
		ACT_RESUMED = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_THR = 1'd0,
		REG_MAX_THR = 1'd1
	} cfg_reg_t;

	// broadcast to every cell
	typedef struct packed {
		logic cap;
		logic add;
		logic rem;
		logic sched;
		logic q_gt_max;
		logic q_lt_min;
	} cell_ctl_t;

	// result gathered along the row
	typedef struct packed {
		logic hit;
		logic active;
		logic paused;
		logic resumed;
	} cell_sum_t;

endpackage

>>> hdl/sorted_flow_pause_scheduler_top.sv
// an item is registered when accepted; its result is registered in the execute cycle
// no new item is accepted until the last one has executed; each cell compares the id and
//   size in the accept cycle and the row shifts or updates in the execute cycle
// an unaccepted result holds the execute cycle, and no new item enters meanwhile
// reset: table empty, thresholds 1280 and 3840, no clearing pass needed
`include "sorted_flow_pause_scheduler_top_assert.svh"

module sorted_flow_pause_scheduler_top #(
	parameter int MAX_FLOWS = sfps_pkg::MAX_FLOWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// cmd[1:0], flow_id[65:2], flow_size[97:66], queue_avg[121:98], zeros above
	input  logic [sfps_pkg::IN_W-1:0]      s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// status[1:0], action[3:2], flow_active[4], window_limit[14:5], zero above
	output logic [sfps_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic [sfps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfps_pkg::THR_W-1:0]     cfg_data
);
	import sfps_pkg::*;

	localparam logic [MAX_FLOWS-1:0] ONE_V = MAX_FLOWS'(1);

	logic              busy_q;
	cmd_t              cmd_s1;
	logic [ID_W-1:0]   id_s1;
	logic [SIZE_W-1:0] size_s1;
	logic [THR_W-1:0]  q_s1;
	logic [THR_W-1:0]  min_q, max_q;

	logic [STATUS_W-1:0] status_q;
	logic [ACTION_W-1:0] action_q;
	logic                active_q;
	logic [WIN_W-1:0]    window_q;

	logic accept, out_free, exec, found, full, add_ok;
	status_t   status_n;
	action_t   action_n;
	cell_ctl_t ctl;
	cell_sum_t sum_last;

	logic [MAX_FLOWS-1:0] valid_v, active_v, ins_v, del_v, match_v;
	logic [ID_W-1:0]      id_a   [MAX_FLOWS];
	logic [SIZE_W-1:0]    size_a [MAX_FLOWS];
	cell_sum_t            sum_a  [MAX_FLOWS];

	assign accept   = s_tvalid & s_tready;
	assign s_tready = ~busy_q;
	assign out_free = ~m_tvalid | m_tready;
	assign exec     = busy_q & out_free;
	assign found    = del_v[MAX_FLOWS-1];
	assign full     = valid_v[MAX_FLOWS-1];
	assign sum_last = sum_a[MAX_FLOWS-1];

	always_comb begin
		ctl.cap      = accept;
		ctl.add      = 1'b0;
		ctl.rem      = 1'b0;
		ctl.sched    = 1'b0;
		ctl.q_gt_max = q_s1 > max_q;
		ctl.q_lt_min = q_s1 < min_q;
		status_n     = ST_OK;
		unique case (cmd_s1)
			CMD_ADD: begin
				if (found)
					status_n = ST_DUP;
				else if (full)
					status_n = ST_FULL;
				else
					ctl.add = exec;
			end
			CMD_REMOVE: begin
				if (!found)
					status_n = ST_NOT_FOUND;
				else
					ctl.rem = exec;
			end
			CMD_SCHED: begin
				if (!found)
					status_n = ST_NOT_FOUND;
				else
					ctl.sched = exec;
			end
			default: status_n = ST_OK;
		endcase
	end

	assign add_ok = ctl.add;

	always_comb begin
		if (sum_last.paused)
			action_n = ACT_PAUSED;
		else if (sum_last.resumed)
			action_n = ACT_RESUMED;
		else
			action_n = ACT_NONE;
	end

	for (genvar i = 0; i < MAX_FLOWS; i++) begin : g_cell
		logic              l_valid, l_active, l_ins, l_del;
		logic [ID_W-1:0]   l_id;
		logic [SIZE_W-1:0] l_size;
		logic              r_valid, r_active;
		logic [ID_W-1:0]   r_id;
		logic [SIZE_W-1:0] r_size;
		cell_sum_t         s_in;

		if (i == 0) begin : g_head
			assign l_valid  = 1'b0;
			assign l_active = 1'b1;
			assign l_ins    = 1'b0;
			assign l_del    = 1'b0;
			assign l_id     = '0;
			assign l_size   = '0;
			assign s_in     = '0;
		end else begin : g_mid
			assign l_valid  = valid_v[i-1];
			assign l_active = active_v[i-1];
			assign l_ins    = ins_v[i-1];
			assign l_del    = del_v[i-1];
			assign l_id     = id_a[i-1];
			assign l_size   = size_a[i-1];
			assign s_in     = sum_a[i-1];
		end

		if (i == MAX_FLOWS-1) begin : g_tail
			assign r_valid  = 1'b0;
			assign r_active = 1'b1;
			assign r_id     = '0;
			assign r_size   = '0;
		end else begin : g_body
			assign r_valid  = valid_v[i+1];
			assign r_active = active_v[i+1];
			assign r_id     = id_a[i+1];
			assign r_size   = size_a[i+1];
		end

		sfps_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.cmp_id       (s_tdata[65:2]),
			.cmp_size     (s_tdata[97:66]),
			.new_id       (id_s1),
			.new_size     (size_s1),
			.left_valid   (l_valid),
			.left_active  (l_active),
			.left_ins     (l_ins),
			.left_del     (l_del),
			.left_id      (l_id),
			.left_size    (l_size),
			.right_valid  (r_valid),
			.right_active (r_active),
			.right_id     (r_id),
			.right_size   (r_size),
			.sum_in       (s_in),
			.valid        (valid_v[i]),
			.active       (active_v[i]),
			.ins          (ins_v[i]),
			.del          (del_v[i]),
			.match        (match_v[i]),
			.id           (id_a[i]),
			.size         (size_a[i]),
			.sum_out      (sum_a[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_THR_RST;
			max_q <= MAX_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_THR: min_q <= cfg_data;
				REG_MAX_THR: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (exec)
				busy_q <= 1'b0;
			if (exec)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(s_tdata[1:0]);
			id_s1   <= s_tdata[65:2];
			size_s1 <= s_tdata[97:66];
			q_s1    <= s_tdata[121:98];
		end
		if (exec) begin
			status_q <= status_n;
			action_q <= action_n;
			active_q <= sum_last.active;
			window_q <= sum_last.paused ? PAUSE_WINDOW : '0;
		end
	end

	assign m_tdata = {1'b0, window_q, active_q, action_q, status_q};

	`SFPS_ASSERT_IMPL(a_single_match, busy_q, $onehot0(match_v), "id matched in two cells")
	`SFPS_ASSERT_IMPL(a_packed_row, 1'b1, (valid_v & (valid_v + ONE_V)) == '0,
		"occupied cells not packed at the head")
	`SFPS_ASSERT_IMPL(a_head_active, valid_v[0], active_v[0], "head flow is paused")
	`SFPS_ASSERT_NEXT(a_add_grows, add_ok,
		$countones(valid_v) == $countones($past(valid_v)) + 1, "add did not grow the table")

endmodule

>>> hdl/sfps_cell.sv
module sfps_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfps_pkg::cell_ctl_t        ctl,
	input  logic [sfps_pkg::ID_W-1:0]   cmp_id,
	input  logic [sfps_pkg::SIZE_W-1:0] cmp_size,
	input  logic [sfps_pkg::ID_W-1:0]   new_id,
	input  logic [sfps_pkg::SIZE_W-1:0] new_size,
	input  logic                       left_valid,
	input  logic                       left_active,
	input  logic                       left_ins,
	input  logic                       left_del,
	input  logic [sfps_pkg::ID_W-1:0]   left_id,
	input  logic [sfps_pkg::SIZE_W-1:0] left_size,
	input  logic                       right_valid,
	input  logic                       right_active,
	input  logic [sfps_pkg::ID_W-1:0]   right_id,
	input  logic [sfps_pkg::SIZE_W-1:0] right_size,
	input  sfps_pkg::cell_sum_t        sum_in,
	output logic                       valid,
	output logic                       active,
	output logic                       ins,
	output logic                       del,
	output logic                       match,
	output logic [sfps_pkg::ID_W-1:0]   id,
	output logic [sfps_pkg::SIZE_W-1:0] size,
	output sfps_pkg::cell_sum_t        sum_out
);
	import sfps_pkg::*;

	logic              valid_q, active_q, match_q, ins_q;
	logic [ID_W-1:0]   id_q, id_n;
	logic [SIZE_W-1:0] size_q, size_n;
	logic              valid_n, active_n;
	logic              at_ins, decel, accel, pause, resume, hit;

	assign valid  = valid_q;
	assign active = active_q;
	assign ins    = ins_q;
	assign match  = match_q;
	assign del    = left_del | match_q;
	assign id     = id_q;
	assign size   = size_q;

	// first cell that is empty or whose size exceeds the new one takes the new entry
	assign at_ins = ins_q & ~left_ins;
	// last active flow on the boundary; a head cell has no valid left neighbor
	assign decel  = active_q & left_valid & (~right_valid | ~right_active);
	assign accel  = ~active_q & left_valid & left_active;
	assign pause  = ctl.sched & match_q & decel & ctl.q_gt_max;
	assign resume = ctl.sched & match_q & accel & ctl.q_lt_min;

	always_comb begin
		id_n     = id_q;
		size_n   = size_q;
		valid_n  = valid_q;
		active_n = active_q;
		if (ctl.add && ins_q) begin
			if (left_ins) begin
				id_n     = left_id;
				size_n   = left_size;
				valid_n  = left_valid;
				active_n = left_active;
			end else begin
				id_n     = new_id;
				size_n   = new_size;
				valid_n  = 1'b1;
				active_n = left_active;
			end
		end
		if (ctl.rem) begin
			if (del) begin
				id_n     = right_id;
				size_n   = right_size;
				valid_n  = right_valid;
				active_n = right_active;
			end
			// head is forced active after a remove
			if (!left_valid)
				active_n = 1'b1;
		end
		if (pause)
			active_n = 1'b0;
		if (resume)
			active_n = 1'b1;
	end

	assign hit = (ctl.add & at_ins) | (ctl.sched & match_q);

	always_comb begin
		sum_out.hit     = sum_in.hit | hit;
		sum_out.active  = sum_in.active | (hit & active_n);
		sum_out.paused  = sum_in.paused | pause;
		sum_out.resumed = sum_in.resumed | resume;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			active_q <= 1'b1;
			match_q  <= 1'b0;
			ins_q    <= 1'b0;
		end else begin
			valid_q  <= valid_n;
			active_q <= active_n;
			if (ctl.cap) begin
				match_q <= valid_q & (id_q == cmp_id);
				ins_q   <= ~valid_q | (cmp_size < size_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= id_n;
		size_q <= size_n;
	end

endmodule
